>>> hdl/fssfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame packer package
// Shared widths, scale constants and the converter request type.
// ----------------------------------------------------------------------------
package fssfp_pkg;

    localparam int NUM_VALUES  = 10;
    localparam int FRAME_WORDS = 9;
    localparam int IDX_W       = 4;
    localparam int IN_W        = 16 + 16 + 32 * NUM_VALUES;

    localparam logic [31:0] K1000 = 32'h447A_0000;
    localparam logic [31:0] K100  = 32'h42C8_0000;

    typedef struct packed {
        logic [31:0] bits;
        logic        big;   // scale by 1000
        logic        wide;  // int32 result
    } conv_req_t;

endpackage

>>> hdl/float_scale_saturate_frame_packer_top.sv
`timescale 1ns / 1ps
// Each value of an accepted record passes the sequencer slot register, the
// scale and convert stage registers and the output register. The single shared
// converter handles one float value per cycle unless the output is stalled,
// ten per record for nine words; the next record is taken in the last slot.
// Reset: aresetn (sync, active low) clears all valid bits and the sequencer.
// ----------------------------------------------------------------------------
// Float scale saturate frame packer
// Converts ten floats through a two-stage pipelined converter and packs words.
// ----------------------------------------------------------------------------
module float_scale_saturate_frame_packer_top
    import fssfp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // fault_code, mode_code, then the ten value bit fields in frame order
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // frame_word[31:0], word_index[35:32], zero fill
    output logic [39:0]      m_tdata,
    output logic             m_tlast
);
    logic [IN_W-1:0] rec_reg;
    logic            busy_reg;
    logic [3:0]      seq_reg;
    logic [3:0]      val_idx;
    logic            en;
    conv_req_t       req;
    logic            v1_reg, v2_reg;
    logic [3:0]      i1_reg, i2_reg;
    logic            s1, nf1, z1, w1;
    logic signed [10:0] e1;
    logic [23:0]     mn1;
    logic [31:0]     code;
    logic [15:0]     half_reg;
    logic            ov_reg;
    logic [31:0]     ow_reg;
    logic [3:0]      oi_reg;
    logic            pw;
    logic [31:0]     pword;
    logic [3:0]      pidx;

    // pipeline advances unless the output holds a word that is not taken
    assign en = !ov_reg || m_tready;
    assign s_tready = en && (!busy_reg || seq_reg == 4'd9);

    // convert the first half of word 5 first so the header can use that slot
    always_comb begin
        case (seq_reg)
            4'd0:    val_idx = 4'd4;
            4'd1:    val_idx = 4'd0;
            4'd2:    val_idx = 4'd1;
            4'd3:    val_idx = 4'd2;
            4'd4:    val_idx = 4'd3;
            default: val_idx = seq_reg;
        endcase
        req.bits = rec_reg[32 + 32*val_idx +: 32];
        req.big  = (val_idx == 4'd0 || val_idx == 4'd1 || val_idx == 4'd4 ||
                    val_idx == 4'd5 || val_idx == 4'd6);
        req.wide = !(val_idx == 4'd4 || val_idx == 4'd5 || val_idx == 4'd8 ||
                     val_idx == 4'd9);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            seq_reg  <= 4'd0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            ov_reg   <= 1'b0;
        end else if (en) begin
            if (s_tvalid && s_tready) begin
                busy_reg <= 1'b1;
                seq_reg  <= 4'd0;
            end else if (busy_reg) begin
                if (seq_reg == 4'd9) begin
                    busy_reg <= 1'b0;
                    seq_reg  <= 4'd0;
                end else begin
                    seq_reg <= seq_reg + 4'd1;
                end
            end
            v1_reg <= busy_reg;
            v2_reg <= v1_reg;
            ov_reg <= pw;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (s_tvalid && s_tready) begin
                rec_reg <= s_tdata;
            end
            i1_reg <= seq_reg;
            i2_reg <= i1_reg;
            if (v2_reg && (i2_reg == 4'd0 || i2_reg == 4'd8)) begin
                half_reg <= code[15:0];
            end
            if (pw) begin
                ow_reg <= pword;
                oi_reg <= pidx;
            end
        end
    end

    // slot to word mapping: header in slot 0, halves pair at slots 0/5 and 8/9
    always_comb begin
        pw    = 1'b0;
        pword = code;
        pidx  = 4'd0;
        if (v2_reg) begin
            case (i2_reg)
                4'd0: begin
                    pw    = 1'b1;
                    pidx  = 4'd0;
                    pword = {rec_reg[15:0], rec_reg[31:16]};
                end
                4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd7: begin
                    pw   = 1'b1;
                    pidx = i2_reg;
                end
                4'd5: begin pw = 1'b1; pidx = 4'd5; pword = {half_reg, code[15:0]}; end
                4'd9: begin pw = 1'b1; pidx = 4'd8; pword = {half_reg, code[15:0]}; end
                default: pw = 1'b0;
            endcase
        end
    end

    fssfp_mul u_mul (
        .aclk(aclk), .en(en), .req(req),
        .sign_reg(s1), .nonfin_reg(nf1), .zero_reg(z1), .wide_reg(w1),
        .exp_reg(e1), .man_reg(mn1)
    );

    fssfp_cvt u_cvt (
        .aclk(aclk), .en(en), .sign_in(s1), .nonfin_in(nf1), .zero_in(z1),
        .wide_in(w1), .exp_in(e1), .man_in(mn1), .code_reg(code)
    );

    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'd0, oi_reg, ow_reg};
    assign m_tlast  = (oi_reg == 4'd8);

`ifndef SYNTHESIS
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> oi_reg == 4'd8) else $error("last flag");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("output dropped");
    a_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> busy_reg) else $error("not busy");
`endif
endmodule

>>> hdl/fssfp_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Float scale stage
// Multiplies a single by 1000 or 100 and rounds to nearest even; registered.
// Output is sign, unbiased-style exponent and 24-bit significand of product.
// ----------------------------------------------------------------------------
module fssfp_mul
    import fssfp_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  conv_req_t         req,
    output logic              sign_reg,
    output logic              nonfin_reg,
    output logic              zero_reg,
    output logic              wide_reg,
    output logic signed [10:0] exp_reg,
    output logic [23:0]       man_reg
);
    logic [7:0]  e;
    logic [22:0] f;
    logic [23:0] m;
    logic [9:0]  k;
    logic [33:0] p;
    logic        top;
    logic [23:0] kept;
    logic        g;
    logic        st;
    logic [24:0] rnd;
    logic signed [10:0] ex;
    logic [4:0]  lz;
    logic        lz_found;
    logic [23:0] mn;
    logic signed [10:0] en_exp;
    logic        sign_next;
    logic        nonfin_next;
    logic        zero_next;
    logic signed [10:0] exp_next;
    logic [23:0] man_next;

    always_comb begin
        e  = req.bits[30:23];
        f  = req.bits[22:0];
        m  = (e == 8'd0) ? {1'b0, f} : {1'b1, f};
        en_exp = (e == 8'd0) ? 11'sd1 : $signed({3'b000, e});
        // normalize subnormal significand
        lz = 5'd0;
        lz_found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!lz_found && m[i]) begin
                lz = 5'(23 - i);
                lz_found = 1'b1;
            end
        end
        mn = m << lz;
        k  = req.big ? 10'd1000 : 10'd100;
        p  = mn * k;
        ex = en_exp - 11'sd127 - $signed({6'd0, lz});
        if (req.big) begin
            // p in [2^32, 2^34)
            top  = p[33];
            ex   = ex + (top ? 11'sd10 : 11'sd9);
            kept = top ? p[33:10] : p[32:9];
            g    = top ? p[9] : p[8];
            st   = top ? (p[8:0] != 0) : (p[7:0] != 0);
        end else begin
            // p in [2^29, 2^31)
            top  = p[30];
            ex   = ex + (top ? 11'sd7 : 11'sd6);
            kept = top ? p[30:7] : p[29:6];
            g    = top ? p[6] : p[5];
            st   = top ? (p[5:0] != 0) : (p[4:0] != 0);
        end
        rnd  = {1'b0, kept} + 25'(g & (st | kept[0]));
        if (rnd[24]) begin
            man_next = rnd[24:1];
            exp_next = ex + 11'sd1;
        end else begin
            man_next = rnd[23:0];
            exp_next = ex;
        end
        sign_next   = req.bits[31];
        nonfin_next = (e == 8'hFF);
        zero_next   = (m == 24'd0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sign_reg   <= sign_next;
            nonfin_reg <= nonfin_next;
            zero_reg   <= zero_next;
            wide_reg   <= req.wide;
            exp_reg    <= exp_next;
            man_reg    <= man_next;
        end
    end
endmodule

>>> hdl/fssfp_cvt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer convert stage
// Truncates a rounded product toward zero to int32 or int16 with saturation.
// ----------------------------------------------------------------------------
module fssfp_cvt
    import fssfp_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic               sign_in,
    input  logic               nonfin_in,
    input  logic               zero_in,
    input  logic               wide_in,
    input  logic signed [10:0] exp_in,
    input  logic [23:0]        man_in,
    output logic [31:0]        code_reg
);
    logic [54:0] sh;
    logic [31:0] mag;
    logic [31:0] code_next;
    logic        sat;

    always_comb begin
        // value = man * 2^(exp-23)
        sh  = '0;
        mag = '0;
        sat = 1'b0;
        if (!zero_in && exp_in >= 11'sd0) begin
            if (exp_in >= 11'sd31) begin
                sat = 1'b1;
            end else begin
                sh  = {31'd0, man_in} << exp_in[4:0];
                mag = sh[54:23];
            end
        end
        if (!wide_in && mag >= 32'd32767) begin
            sat = 1'b1;
        end
        if (nonfin_in) begin
            code_next = wide_in ? 32'h8000_0000 : 32'h0000_8000;
        end else if (sat) begin
            if (wide_in) begin
                code_next = sign_in ? 32'h8000_0001 : 32'h7FFF_FFFF;
            end else begin
                code_next = sign_in ? 32'h0000_8001 : 32'h0000_7FFF;
            end
        end else begin
            code_next = sign_in ? (32'd0 - mag) : mag;
            if (!wide_in) begin
                code_next = {16'd0, code_next[15:0]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            code_reg <= code_next;
        end
    end
endmodule
